// ===== rtl/rice_pkg.sv =====
// Shared types and constants for the signed Rice coefficient encoder.
// Used by rice_ctrl, rice_dp and the top level; depends on nothing.
package rice_pkg;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;
    localparam logic [1:0] ST_CAP   = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CAP  = 2'd1;

    // register reset values
    localparam logic [3:0]  LOW_BITS_RST = 4'd5;
    localparam logic [15:0] OUT_CAP_RST  = 16'd1024;

    // width of a code length sum: pending + 2 + low_bits + quotient stays below 1024
    localparam int LEN_W = 11;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       accept;      // latch the incoming word
        logic       build;       // register code word and lengths
        logic       merge;       // shift code word into the accumulator
        logic       emit_byte;   // send one whole byte
        logic       emit_flush;  // send the padded leftover bits
        logic       emit_err;    // send an error word
        logic [1:0] err_code;
        logic       clear_run;
        logic       set_fail;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic       run_failed;
        logic [1:0] fail_code;
        logic       last_in;
        logic       range_bad;
        logic       overflow;
        logic       room;
        logic       cnt_ge8;
        logic       cnt_nz;
        logic       out_free;
    } stat_t;

endpackage

// ===== rtl/rice_ctrl.sv =====
// Sequencer of the signed Rice coefficient encoder.
// Uses rice_pkg command and status structs; drives rice_dp.
module rice_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rice_pkg::stat_t stat,
    output rice_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MERGE = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] code_reg, code_next;

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.err_code = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.run_failed) begin
                    code_next  = stat.fail_code;
                    state_next = stat.last_in ? S_ERR : S_IDLE;
                end else if (stat.range_bad) begin
                    code_next  = rice_pkg::ST_RANGE;
                    state_next = S_ERR;
                end else if (stat.overflow) begin
                    code_next  = rice_pkg::ST_OVF;
                    state_next = S_ERR;
                end else begin
                    cmd.build  = 1'b1;
                    state_next = S_MERGE;
                end
            end
            S_MERGE: begin
                cmd.merge  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.cnt_ge8) begin
                    if (!stat.room) begin
                        code_next  = rice_pkg::ST_CAP;
                        state_next = S_ERR;
                    end else if (stat.out_free) begin
                        cmd.emit_byte = 1'b1;
                    end
                end else if (stat.last_in) begin
                    if (!stat.cnt_nz) begin
                        cmd.clear_run = 1'b1;
                        state_next    = S_IDLE;
                    end else if (!stat.room) begin
                        code_next  = rice_pkg::ST_CAP;
                        state_next = S_ERR;
                    end else if (stat.out_free) begin
                        cmd.emit_flush = 1'b1;
                        cmd.clear_run  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_ERR: begin
                if (stat.out_free) begin
                    cmd.emit_err  = 1'b1;
                    cmd.clear_run = stat.last_in;
                    cmd.set_fail  = !stat.last_in;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= rice_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

// ===== rtl/rice_dp.sv =====
// Datapath of the signed Rice coefficient encoder: input latch, code builder,
// bit accumulator, byte extraction, run counters and output register. Uses rice_pkg.
module rice_dp #(
    parameter int ACC_BITS    = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [15:0]                   s_coeff,
    input  logic                          s_last_coeff,
    input  logic                          cfg_valid,
    input  logic [rice_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic [1:0]                    m_status,
    output logic [15:0]                   m_total_bytes,
    output logic                          m_last_of_run,
    input  rice_pkg::cmd_t                cmd,
    output rice_pkg::stat_t               stat
);

    localparam int PW = $clog2(ACC_BITS);
    localparam int LW = rice_pkg::LEN_W;

    // configuration
    logic [3:0]  low_bits_reg;
    logic [15:0] out_cap_reg;

    // latched input word
    logic [15:0] coeff_reg;
    logic        last_reg;

    // run state
    logic [ACC_BITS-1:0]    acc_reg;
    logic [PW-1:0]          cnt_reg;
    logic [COUNT_WIDTH-1:0] bytes_reg;
    logic                   failed_reg;
    logic [1:0]             fail_code_reg;

    // built code word
    logic [ACC_BITS-1:0] code_reg;
    logic [LW-1:0]       nbits_reg;
    logic [LW-1:0]       len_reg;

    // output register
    logic        m_valid_reg;
    logic [7:0]  byte_reg;
    logic [1:0]  status_reg;
    logic [15:0] total_reg;
    logic        lastr_reg;

    logic           sign;
    logic [8:0]     w;
    logic [8:0]     q;
    logic [16:0]    field;
    logic [LW-1:0]  nbits;
    logic [LW-1:0]  len;
    logic           out_free;
    logic [COUNT_WIDTH-1:0] bytes_inc;
    logic [7:0]     full_byte;
    logic [7:0]     flush_byte;
    logic [PW-1:0]  cnt_sub8;

    // magnitude split of the latched coefficient
    assign sign  = coeff_reg[15];
    assign w     = sign ? ~coeff_reg[8:0] : coeff_reg[8:0];
    assign q     = w >> low_bits_reg;
    assign field = (17'(sign) << low_bits_reg) | (17'(w) & ((17'd1 << low_bits_reg) - 17'd1));
    assign nbits = LW'(q) + LW'(low_bits_reg) + LW'(2);
    assign len   = LW'(cnt_reg) + nbits;

    assign out_free  = !m_valid_reg || m_ready;
    assign bytes_inc = bytes_reg + COUNT_WIDTH'(1);
    assign cnt_sub8  = cnt_reg - PW'(8);
    assign full_byte = 8'(acc_reg >> cnt_sub8);
    assign flush_byte = 8'(acc_reg[7:0] << (4'd8 - 4'(cnt_reg)));

    // status to the sequencer
    always_comb begin
        stat.run_failed = failed_reg;
        stat.fail_code  = fail_code_reg;
        stat.last_in    = last_reg;
        stat.range_bad  = !((coeff_reg[15:9] == 7'h00) || (coeff_reg[15:9] == 7'h7f));
        stat.overflow   = (len >= LW'(ACC_BITS));
        stat.room       = (32'(bytes_reg) < 32'(out_cap_reg)) && (bytes_reg != '1);
        stat.cnt_ge8    = (cnt_reg >= PW'(8));
        stat.cnt_nz     = (cnt_reg != '0);
        stat.out_free   = out_free;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_bits_reg <= rice_pkg::LOW_BITS_RST;
            out_cap_reg  <= rice_pkg::OUT_CAP_RST;
        end else if (cfg_valid) begin
            if (cfg_index == rice_pkg::REG_LOW_BITS) begin
                low_bits_reg <= cfg_data[3:0];
            end else if (cfg_index == rice_pkg::REG_OUT_CAP) begin
                out_cap_reg <= cfg_data;
            end
        end
    end

    // input latch and code word
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            coeff_reg <= s_coeff;
            last_reg  <= s_last_coeff;
        end
        if (cmd.build) begin
            code_reg  <= (ACC_BITS'(field) << (q + 9'd1)) | ACC_BITS'(1);
            nbits_reg <= nbits;
            len_reg   <= len;
        end
    end

    // accumulator and run counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            bytes_reg     <= '0;
            failed_reg    <= 1'b0;
            fail_code_reg <= rice_pkg::ST_OK;
        end else begin
            if (cmd.merge) begin
                acc_reg <= (acc_reg << nbits_reg) | code_reg;
                cnt_reg <= PW'(len_reg);
            end
            if (cmd.emit_byte) begin
                cnt_reg   <= cnt_sub8;
                bytes_reg <= bytes_inc;
            end
            if (cmd.set_fail) begin
                failed_reg    <= 1'b1;
                fail_code_reg <= cmd.err_code;
            end
            if (cmd.clear_run) begin
                acc_reg       <= '0;
                cnt_reg       <= '0;
                bytes_reg     <= '0;
                failed_reg    <= 1'b0;
                fail_code_reg <= rice_pkg::ST_OK;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_byte || cmd.emit_flush || cmd.emit_err) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_byte) begin
            byte_reg   <= full_byte;
            status_reg <= rice_pkg::ST_OK;
            total_reg  <= 16'(bytes_inc);
            lastr_reg  <= last_reg && (cnt_reg == PW'(8));
        end else if (cmd.emit_flush) begin
            byte_reg   <= flush_byte;
            status_reg <= rice_pkg::ST_OK;
            total_reg  <= 16'(bytes_inc);
            lastr_reg  <= 1'b1;
        end else if (cmd.emit_err) begin
            byte_reg   <= 8'd0;
            status_reg <= cmd.err_code;
            total_reg  <= 16'(bytes_reg);
            lastr_reg  <= last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_status      = status_reg;
    assign m_total_bytes = total_reg;
    assign m_last_of_run = lastr_reg;

endmodule

// ===== rtl/signed_rice_coefficient_encoder.sv =====
// Signed Rice coefficient encoder, top level: ties rice_ctrl and rice_dp together.
// Uses rice_pkg for command, status and code constants.
//
// Each accepted coefficient is appended to a bit accumulator as a sign bit, the low
// low_bits bits of its magnitude word and a unary tail, and whole bytes leave most
// significant bit first, one result word per byte; the word marked last_coeff flushes
// the leftover bits zero padded and ends the run, and its final result carries
// last_of_run. An item passes accept, check, accumulator merge, the extraction loop
// of the sequencer that sends one byte per pass, then a closing step that also sends
// the padded flush byte; the output register can be held by m_ready low, and a
// capacity error ends the item with an error word. An item that fails the range or
// overflow check, or the last item of a failed run, passes accept, check and its
// error word; any other item of a failed run passes only accept and check. A failed
// run reports its error once, then again on the last item; bytes already sent in that
// run are to be dropped. Configuration is written at index 0 (low_bits) and 1
// (out_capacity); the user must write it while idle; the block does not enforce it.
module signed_rice_coefficient_encoder #(
    parameter int ACC_BITS    = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [15:0]                   s_coeff,
    input  logic                          s_last_coeff,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic [1:0]                    m_status,
    output logic [15:0]                   m_total_bytes,
    output logic                          m_last_of_run,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rice_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    rice_pkg::cmd_t  cmd;
    rice_pkg::stat_t stat;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    rice_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath
    rice_dp #(
        .ACC_BITS    (ACC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_coeff       (s_coeff),
        .s_last_coeff  (s_last_coeff),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_status      (m_status),
        .m_total_bytes (m_total_bytes),
        .m_last_of_run (m_last_of_run),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// ===== dv/tb_signed_rice_coefficient_encoder.sv =====
// Self-checking testbench for signed_rice_coefficient_encoder: directed and random runs
// of coefficients, each output word compared against an in-bench Rice packing predictor.
// Depends on rice_pkg and the encoder RTL only.
module tb_signed_rice_coefficient_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACC_BITS     = 64;
    localparam int COUNT_MAX    = (1 << 16) - 1;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 85;
    localparam int REPORT_MAX   = 10;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

    // one packed output word as the encoder should send it
    typedef struct {
        logic [7:0]  out_byte;
        logic [1:0]  status;
        logic [15:0] total;
        logic        last;
    } packed_word_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [15:0]                    s_coeff = '0;
    logic                           s_last_coeff = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [7:0]                     m_out_byte;
    logic [1:0]                     m_status;
    logic [15:0]                    m_total_bytes;
    logic                           m_last_of_run;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rice_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]                    cfg_data = '0;

    // predictor state and its copy of the registers
    logic [63:0]  acc_bits = '0;
    int           pend_bits = 0;
    int           run_bytes = 0;
    bit           run_bad = 1'b0;
    logic [1:0]   bad_code = rice_pkg::ST_OK;
    logic [3:0]   cfg_low_bits = rice_pkg::LOW_BITS_RST;
    logic [15:0]  cfg_capacity = rice_pkg::OUT_CAP_RST;

    packed_word_t owed_words[$];
    int           bad_count = 0;
    int           burst_left = 0;

    signed_rice_coefficient_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coeff       (s_coeff),
        .s_last_coeff  (s_last_coeff),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_status      (m_status),
        .m_total_bytes (m_total_bytes),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // hard stop
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_run();
        acc_bits  = '0;
        pend_bits = 0;
        run_bytes = 0;
        run_bad   = 1'b0;
        bad_code  = rice_pkg::ST_OK;
    endfunction

    function automatic void owe_word(input logic [7:0] b, input logic [1:0] st,
                                     input logic lst);
        packed_word_t w;
        w.out_byte = b;
        w.status   = st;
        w.total    = run_bytes[15:0];
        w.last     = lst;
        owed_words.push_back(w);
    endfunction

    // error word; a non-last item leaves the run marked failed
    function automatic void fail_run(input logic [1:0] code, input logic lst);
        owe_word(8'h00, code, lst);
        if (lst) begin
            clear_run();
        end else begin
            run_bad  = 1'b1;
            bad_code = code;
        end
    endfunction

    function automatic bit room_left();
        return run_bytes < int'(cfg_capacity) && run_bytes < COUNT_MAX;
    endfunction

    // append one coefficient's code and owe every byte it completes
    function automatic void encode_coeff(input logic [15:0] raw, input logic lst);
        int          x;
        int          w;
        int          lb;
        int          q;
        int          len;
        logic [63:0] acc;
        if (run_bad) begin
            if (lst)
                fail_run(bad_code, 1'b1);
            return;
        end
        x = int'($signed(raw));
        if (x < -512 || x > 511) begin
            fail_run(rice_pkg::ST_RANGE, lst);
            return;
        end
        w   = (x < 0) ? -(x + 1) : x;
        lb  = int'(cfg_low_bits);
        q   = w >>> lb;
        len = pend_bits + 2 + lb + q;
        if (len >= ACC_BITS) begin
            fail_run(rice_pkg::ST_OVF, lst);
            return;
        end
        // sign, verbatim low bits, then zeros closed by a one
        acc = (acc_bits << 1) | ((x < 0) ? 64'd1 : 64'd0);
        acc = (acc << lb) | (64'(w) & ((64'd1 << lb) - 64'd1));
        acc = (acc << (q + 1)) | 64'd1;
        while (len >= 8) begin
            if (!room_left()) begin
                fail_run(rice_pkg::ST_CAP, lst);
                return;
            end
            len -= 8;
            run_bytes++;
            owe_word(8'(acc >> len), rice_pkg::ST_OK, lst && len == 0);
        end
        if (lst) begin
            if (len > 0) begin
                if (!room_left()) begin
                    fail_run(rice_pkg::ST_CAP, 1'b1);
                    return;
                end
                run_bytes++;
                owe_word(8'(acc << (8 - len)), rice_pkg::ST_OK, 1'b1);
            end
            clear_run();
            return;
        end
        acc_bits  = acc;
        pend_bits = len;
    endfunction

    // ---------------------------------------------------------------- drivers

    // send one coefficient word, with bursts and random gaps between them
    task automatic push_coeff(input logic [15:0] c, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_coeff      <= c;
        s_last_coeff <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        encode_coeff(c, lst);
        burst_left--;
    endtask

    task automatic write_reg(input logic [rice_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == rice_pkg::REG_LOW_BITS)
            cfg_low_bits = data[3:0];
        else if (idx == rice_pkg::REG_OUT_CAP)
            cfg_capacity = data;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, let every owed word arrive, then let the sequencer settle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // receiver stalls, switching between its own patterns
    rx_mode_e    rx_mode = RX_OPEN;
    int unsigned rx_mode_left = 0;
    int unsigned rx_tick = 0;

    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode_left = $urandom_range(20, 80);
            rx_mode      = rx_mode_e'($urandom_range(0, 2));
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 2) != 0);
            default:   m_ready <= (rx_tick % 9) >= 5;
        endcase
    end

    // ---------------------------------------------------------------- checker

    always @(posedge aclk) begin
        packed_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_words.size() == 0) begin
                if (bad_count < REPORT_MAX)
                    $display("%0t: unexpected word byte %02h status %0d total %0d last %0d",
                             $realtime, m_out_byte, m_status, m_total_bytes, m_last_of_run);
                bad_count++;
            end else begin
                want = owed_words.pop_front();
                if (m_out_byte !== want.out_byte || m_status !== want.status ||
                    m_total_bytes !== want.total || m_last_of_run !== want.last) begin
                    if (bad_count < REPORT_MAX) begin
                        $write("%0t: word mismatch (want/got) byte %02h/%02h ",
                               $realtime, want.out_byte, m_out_byte);
                        $display("status %0d/%0d total %0d/%0d last %0d/%0d",
                                 want.status, m_status, want.total, m_total_bytes,
                                 want.last, m_last_of_run);
                    end
                    bad_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reset register values, in-range extremes of the coefficient
    task automatic test_reset_config();
        push_coeff(16'sd0, 1'b0);
        push_coeff(-16'sd1, 1'b0);
        push_coeff(16'sd511, 1'b0);
        push_coeff(-16'sd512, 1'b1);
    endtask

    // out of range values mid-run and on the last word
    task automatic test_range_errors();
        push_coeff(16'sd512, 1'b0);
        push_coeff(16'sd5, 1'b0);
        push_coeff(-16'sd32768, 1'b1);
        push_coeff(16'sd32767, 1'b1);
        push_coeff(-16'sd513, 1'b1);
    endtask

    // smallest, largest and oversized low_bits (empty unary part)
    task automatic test_low_bits();
        wait_idle();
        write_reg(rice_pkg::REG_LOW_BITS, 16'h0000);
        push_coeff(16'sd0, 1'b0);
        push_coeff(-16'sd1, 1'b0);
        push_coeff(16'sd3, 1'b1);
        wait_idle();
        write_reg(rice_pkg::REG_LOW_BITS, 16'hA5C9);
        push_coeff(16'sd511, 1'b0);
        push_coeff(-16'sd512, 1'b1);
        wait_idle();
        write_reg(rice_pkg::REG_LOW_BITS, 16'h000F);
        push_coeff(-16'sd300, 1'b0);
        push_coeff(16'sd7, 1'b1);
    endtask

    // accumulator full: longest legal code, then just past it
    task automatic test_overflow();
        wait_idle();
        write_reg(rice_pkg::REG_LOW_BITS, 16'h0000);
        push_coeff(16'sd61, 1'b1);
        push_coeff(16'sd62, 1'b1);
        push_coeff(16'sd40, 1'b0);
        push_coeff(16'sd60, 1'b0);
        push_coeff(16'sd1, 1'b1);
    endtask

    // byte budget: none, two, then the largest
    task automatic test_capacity();
        wait_idle();
        write_reg(rice_pkg::REG_LOW_BITS, 16'h0005);
        write_reg(rice_pkg::REG_OUT_CAP, 16'd0);
        push_coeff(16'sd0, 1'b1);
        wait_idle();
        write_reg(rice_pkg::REG_OUT_CAP, 16'd2);
        push_coeff(-16'sd512, 1'b0);
        push_coeff(16'sd100, 1'b0);
        push_coeff(16'sd3, 1'b1);
        wait_idle();
        write_reg(rice_pkg::REG_OUT_CAP, 16'hFFFF);
        push_coeff(16'sd9, 1'b1);
    endtask

    // mostly small in-range values scaled to low_bits, some full range, some junk
    function automatic logic [15:0] pick_coeff();
        int pick;
        int span;
        int mag;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            span = 1 << (int'(cfg_low_bits) + 2);
            if (span > 512)
                span = 512;
            mag = $urandom_range(0, span - 1);
            return ($urandom_range(0, 1) != 0) ? 16'(-mag - 1) : 16'(mag);
        end
        if (pick < 90)
            return 16'(int'($urandom_range(0, 1023)) - 512);
        return 16'($urandom_range(0, 65535));
    endfunction

    // random runs, registers changed between some of them
    task automatic test_random_runs();
        int sent;
        int run_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                if ($urandom_range(0, 9) < 7)
                    write_reg(rice_pkg::REG_LOW_BITS, 16'($urandom_range(2, 7)));
                else
                    write_reg(rice_pkg::REG_LOW_BITS, 16'($urandom_range(0, 65535)));
                case ($urandom_range(0, 4))
                    0: write_reg(rice_pkg::REG_OUT_CAP, 16'($urandom_range(0, 12)));
                    1: write_reg(rice_pkg::REG_OUT_CAP, 16'hFFFF);
                    2: write_reg(rice_pkg::REG_OUT_CAP, 16'($urandom_range(0, 65535)));
                    default: write_reg(rice_pkg::REG_OUT_CAP, rice_pkg::OUT_CAP_RST);
                endcase
            end
            run_len = $urandom_range(1, 10);
            for (int i = 0; i < run_len; i++) begin
                push_coeff(pick_coeff(), i == run_len - 1);
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_config();
        test_range_errors();
        test_low_bits();
        test_overflow();
        test_capacity();
        test_random_runs();
        wait_idle();
        if (owed_words.size() != 0) begin
            $display("%0d expected words never arrived", owed_words.size());
            bad_count++;
        end
        if (bad_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
